// ----- src/pnf_pkg.sv -----
package pnf_pkg;

	localparam int ARG_W   = 64;
	localparam int CHAR_W  = 8;
	localparam int KIND_W  = 3;
	localparam int DEC_DIGITS = 10;
	localparam int OCT_DIGITS = 11;
	localparam int HEX_DIGITS = 16;
	localparam int BCD_W   = 4 * DEC_DIGITS;
	localparam int IDX_W   = 4;
	localparam int DAB_W   = 5;

	localparam logic [KIND_W-1:0] KIND_PERCENT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CHAR    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SDEC    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_UDEC    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_OCT     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_HEX     = 3'd5;

	localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_X       = 8'h78;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_A       = 8'h61;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ARG_W-1:0]  argument;
	} pnf_in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} pnf_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ONE,
		ST_MINUS,
		ST_CONVERT,
		ST_PFX0,
		ST_PFXX,
		ST_FIND,
		ST_DIGITS
	} pnf_state_t;

	typedef enum logic [2:0] {
		SEL_SINGLE,
		SEL_ZERO,
		SEL_X,
		SEL_MINUS,
		SEL_DIGIT
	} pnf_sel_t;

	typedef struct packed {
		logic     load;
		logic     dab_step;
		logic     find;
		logic     digit_step;
		logic     emit;
		logic     last;
		pnf_sel_t sel;
	} pnf_cmd_t;

	typedef struct packed {
		logic dab_last;
		logic idx_zero;
	} pnf_stat_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		if (d < 4'd10) begin
			digit_char = CH_ZERO + {4'd0, d};
		end else begin
			digit_char = CH_A + {4'd0, d} - 8'd10;
		end
	endfunction

endpackage

// ----- src/pnf_ctrl.sv -----
module pnf_ctrl
	import pnf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KIND_W-1:0] kind,
	input  logic              sign,
	input  pnf_stat_t         stat,
	output pnf_cmd_t          cmd,
	output logic              busy
);

	pnf_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (kind)
						KIND_PERCENT, KIND_CHAR: state_d = ST_ONE;
						KIND_SDEC:               state_d = sign ? ST_MINUS : ST_CONVERT;
						KIND_UDEC:               state_d = ST_CONVERT;
						KIND_OCT, KIND_HEX:      state_d = ST_FIND;
						default:                 state_d = ST_PFX0;
					endcase
				end
			end
			ST_ONE:     state_d = ST_IDLE;
			ST_MINUS:   state_d = ST_CONVERT;
			ST_CONVERT: if (stat.dab_last) state_d = ST_FIND;
			ST_PFX0:    state_d = ST_PFXX;
			ST_PFXX:    state_d = ST_FIND;
			ST_FIND:    state_d = ST_DIGITS;
			ST_DIGITS:  if (stat.idx_zero) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '{load: 1'b0, dab_step: 1'b0, find: 1'b0, digit_step: 1'b0,
			emit: 1'b0, last: 1'b0, sel: SEL_SINGLE};
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
			end
			ST_ONE: begin
				cmd.emit = 1'b1;
				cmd.last = 1'b1;
				cmd.sel  = SEL_SINGLE;
			end
			ST_MINUS: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_MINUS;
			end
			ST_CONVERT: cmd.dab_step = 1'b1;
			ST_PFX0: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_ZERO;
			end
			ST_PFXX: begin
				cmd.emit = 1'b1;
				cmd.sel  = SEL_X;
			end
			ST_FIND: cmd.find = 1'b1;
			ST_DIGITS: begin
				cmd.emit       = 1'b1;
				cmd.sel        = SEL_DIGIT;
				cmd.digit_step = 1'b1;
				cmd.last       = stat.idx_zero;
			end
			default: busy = 1'b1;
		endcase
	end

endmodule

// ----- src/pnf_datapath.sv -----
module pnf_datapath
	import pnf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pnf_in_t   request,
	input  pnf_cmd_t  cmd,
	output pnf_stat_t stat,
	output pnf_out_t  result,
	output logic      strobe
);

	logic [KIND_W-1:0] kind_q;
	logic [ARG_W-1:0]  val_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [DAB_W-1:0]  dab_cnt_q;
	logic [IDX_W-1:0]  idx_q;
	pnf_out_t          out_q;
	logic              strobe_q;

	logic              is_dec, is_oct;
	logic [31:0]       low32, mag32;
	logic [ARG_W-1:0]  load_val;
	logic [BCD_W-1:0]  bcd_adj;
	logic [IDX_W-1:0]  lead_idx;
	logic [3:0]        cur_digit;
	logic [CHAR_W-1:0] char_d;

	assign is_dec = (kind_q == KIND_SDEC) || (kind_q == KIND_UDEC);
	assign is_oct = (kind_q == KIND_OCT);

	assign low32 = request.argument[31:0];
	assign mag32 = 32'd0 - low32;

	always_comb begin
		unique case (request.kind)
			KIND_PERCENT, KIND_CHAR, KIND_UDEC, KIND_OCT, KIND_HEX:
				load_val = {32'd0, low32};
			KIND_SDEC:
				load_val = {32'd0, low32[31] ? mag32 : low32};
			default:
				load_val = request.argument;
		endcase
	end

	// shift-add-3: bump digits of 5 or more before each shift
	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	// highest nonzero digit; stays 0 for a zero value so one '0' prints
	always_comb begin
		lead_idx = '0;
		if (is_dec) begin
			for (int i = 0; i < DEC_DIGITS; i++) begin
				if (bcd_q[4*i +: 4] != 4'd0) lead_idx = IDX_W'(i);
			end
		end else if (is_oct) begin
			for (int i = 0; i < OCT_DIGITS; i++) begin
				if (val_q[3*i +: 3] != 3'd0) lead_idx = IDX_W'(i);
			end
		end else begin
			for (int i = 0; i < HEX_DIGITS; i++) begin
				if (val_q[4*i +: 4] != 4'd0) lead_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		cur_digit = '0;
		if (is_dec) begin
			for (int i = 0; i < DEC_DIGITS; i++) begin
				if (idx_q == IDX_W'(i)) cur_digit = bcd_q[4*i +: 4];
			end
		end else if (is_oct) begin
			for (int i = 0; i < OCT_DIGITS; i++) begin
				if (idx_q == IDX_W'(i)) cur_digit = {1'b0, val_q[3*i +: 3]};
			end
		end else begin
			for (int i = 0; i < HEX_DIGITS; i++) begin
				if (idx_q == IDX_W'(i)) cur_digit = val_q[4*i +: 4];
			end
		end
	end

	always_comb begin
		unique case (cmd.sel)
			SEL_SINGLE: char_d = (kind_q == KIND_PERCENT) ? CH_PERCENT : val_q[7:0];
			SEL_ZERO:   char_d = CH_ZERO;
			SEL_X:      char_d = CH_X;
			SEL_MINUS:  char_d = CH_MINUS;
			SEL_DIGIT:  char_d = digit_char(cur_digit);
			default:    char_d = CH_ZERO;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= request.kind;
			val_q     <= load_val;
			bcd_q     <= '0;
			dab_cnt_q <= '0;
		end else if (cmd.dab_step) begin
			bcd_q     <= {bcd_adj[BCD_W-2:0], val_q[31]};
			val_q     <= {val_q[ARG_W-2:0], 1'b0};
			dab_cnt_q <= dab_cnt_q + DAB_W'(1);
		end
		if (cmd.find) begin
			idx_q <= lead_idx;
		end else if (cmd.digit_step) begin
			idx_q <= idx_q - IDX_W'(1);
		end
		if (cmd.emit) begin
			out_q.character <= char_d;
			out_q.last      <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	assign stat.dab_last = (dab_cnt_q == {DAB_W{1'b1}});
	assign stat.idx_zero = (idx_q == '0);
	assign result = out_q;
	assign strobe = strobe_q;

endmodule

// ----- src/printf_number_formatter_core.sv -----
// channel   signals                     direction  handshake
// request   start, busy, request        in         taken when start & !busy
// result    strobe, result              out        one strobe per character, no stall
//
// Digits leave one per cycle; each character is formed combinationally and registered before it leaves.
// Percent and char emit one character. Octal/hex: a find step, then the digits. Pointer: '0', 'x', find, digits.
// Decimal: a minus sign if negative, 32 shift-add-3 steps, a find step, then the digits.
// busy drops as the last character is registered; a new item may start then.
// Reset clears the controller and the strobe; the receiver cannot stall.
module printf_number_formatter_core
	import pnf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  pnf_in_t  request,
	output pnf_out_t result,
	output logic     strobe
);

	pnf_cmd_t  cmd;
	pnf_stat_t stat;

	pnf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (request.kind),
		.sign   (request.argument[31]),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	pnf_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.result  (result),
		.strobe  (strobe)
	);

endmodule

// ----- bench/printf_number_formatter_core_tb.sv -----
`timescale 1ns / 1ps

module printf_number_formatter_core_tb;
	import pnf_pkg::*;

	localparam logic [KIND_W-1:0] KIND_PTR   = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 60;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	pnf_in_t  request = '0;
	pnf_out_t result;
	logic     strobe;

	pnf_out_t chars_due[$];
	int       mismatches = 0;
	int       cycles = 0;
	bit       gaps_on = 1'b1;

	// directed table; an empty text means the predictor supplies the characters
	logic [KIND_W-1:0] row_kind[$];
	logic [ARG_W-1:0]  row_arg[$];
	string             row_text[$];

	printf_number_formatter_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.result (result),
		.strobe (strobe)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void enqueue_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			chars_due.push_back('{character: s[i], last: (i == s.len() - 1)});
		end
	endfunction

	function automatic void predict_conversion(pnf_in_t req);
		string            hex_set = "0123456789abcdef";
		logic [CHAR_W-1:0] text[$];
		logic [CHAR_W-1:0] digs[24];
		logic [31:0]       low;
		logic [31:0]       mag;
		logic [ARG_W-1:0]  v;
		int                radix;
		int                cnt;
		bit                numeric;
		low = req.argument[31:0];
		numeric = 1'b1;
		v = '0;
		radix = 16;
		case (req.kind)
			KIND_PERCENT: begin
				text.push_back(CH_PERCENT);
				numeric = 1'b0;
			end
			KIND_CHAR: begin
				text.push_back(req.argument[7:0]);
				numeric = 1'b0;
			end
			KIND_SDEC: begin
				radix = 10;
				if (low[31]) begin
					text.push_back(CH_MINUS);
					mag = -low;
					v = {32'd0, mag};
				end else begin
					v = {32'd0, low};
				end
			end
			KIND_UDEC: begin
				radix = 10;
				v = {32'd0, low};
			end
			KIND_OCT: begin
				radix = 8;
				v = {32'd0, low};
			end
			KIND_HEX: begin
				v = {32'd0, low};
			end
			default: begin
				// pointer, and the spare code behaves the same
				text.push_back(CH_ZERO);
				text.push_back(CH_X);
				v = req.argument;
			end
		endcase
		if (numeric) begin
			if (v == 0) begin
				text.push_back(CH_ZERO);
			end else begin
				cnt = 0;
				while (v != 0) begin
					digs[cnt] = hex_set[int'(v % radix)];
					cnt++;
					v = v / radix;
				end
				for (int k = cnt - 1; k >= 0; k--) begin
					text.push_back(digs[k]);
				end
			end
		end
		for (int i = 0; i < text.size(); i++) begin
			chars_due.push_back('{character: text[i], last: (i == text.size() - 1)});
		end
	endfunction

	function automatic void add_row(logic [KIND_W-1:0] k, logic [ARG_W-1:0] a, string s);
		row_kind.push_back(k);
		row_arg.push_back(a);
		row_text.push_back(s);
	endfunction

	task automatic send_item(input pnf_in_t item, input string want);
		while (gaps_on && $urandom_range(0, 99) < 21) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= item;
		do @(posedge clk); while (busy);
		if (want.len() == 0) begin
			predict_conversion(item);
		end else begin
			enqueue_text(want);
		end
	endtask

	// every strobed character is matched against the oldest one still due
	always @(posedge clk) begin
		pnf_out_t want;
		if (arst_n && strobe) begin
			if (chars_due.size() == 0) begin
				$error("character: expected none, got %h (last %b)",
					result.character, result.last);
				mismatches++;
			end else begin
				want = chars_due.pop_front();
				if (result.character !== want.character) begin
					$error("character: expected %h, got %h", want.character,
						result.character);
					mismatches++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, result.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[printf_number_formatter_core] ERROR");
			$finish;
		end
	end

	initial begin
		pnf_in_t     item;
		logic [31:0] near;
		add_row(KIND_PERCENT, 64'h0, "%");
		add_row(KIND_PERCENT, 64'hffff_ffff_ffff_ffff, "%");
		add_row(KIND_CHAR, 64'h41, "A");
		add_row(KIND_CHAR, 64'h0, "");                   // NUL byte comes out as is
		add_row(KIND_CHAR, 64'hffff_ffff_ffff_ff7a, "z");
		add_row(KIND_CHAR, 64'hff, "");
		add_row(KIND_SDEC, 64'h0, "0");
		add_row(KIND_SDEC, 64'h7fff_ffff, "2147483647");
		add_row(KIND_SDEC, 64'h8000_0000, "-2147483648");
		add_row(KIND_SDEC, 64'hffff_ffff, "-1");
		add_row(KIND_SDEC, 64'hdead_beef_0000_0005, "5");
		add_row(KIND_UDEC, 64'h0, "0");
		add_row(KIND_UDEC, 64'hffff_ffff, "4294967295");
		add_row(KIND_UDEC, 64'h1234_5678_0001_e240, "");
		add_row(KIND_OCT, 64'h0, "0");
		add_row(KIND_OCT, 64'hffff_ffff, "37777777777");
		add_row(KIND_OCT, 64'h8, "10");
		add_row(KIND_HEX, 64'h0, "0");
		add_row(KIND_HEX, 64'hffff_ffff, "ffffffff");
		add_row(KIND_HEX, 64'habcd_0000_1234_abcd, "");
		add_row(KIND_PTR, 64'h0, "0x0");
		add_row(KIND_PTR, 64'hffff_ffff_ffff_ffff, "0xffffffffffffffff");
		add_row(KIND_PTR, 64'h8000_0000_0000_0000, "");
		add_row(KIND_SPARE, 64'h1, "0x1");
		add_row(KIND_SPARE, 64'h0123_4567_89ab_cdef, "");

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < row_kind.size(); r++) begin
			item.kind = row_kind[r];
			item.argument = row_arg[r];
			send_item(item, row_text[r]);
		end

		for (int n = 0; n < 360; n++) begin
			gaps_on = !(n >= 150 && n < 230);
			item.kind = KIND_W'($urandom_range(0, 7));
			near = 32'($urandom_range(0, 4));
			case ($urandom_range(0, 5))
				0: item.argument = {$urandom, $urandom};
				1: item.argument = {$urandom, $urandom}
					& ((64'd1 << $urandom_range(1, 63)) - 64'd1);
				2: item.argument = {$urandom, 32'h7fff_fffe + near};
				3: item.argument = {$urandom, 32'hffff_ffff - near};
				4: item.argument = {$urandom, 32'($urandom_range(0, 20))};
				default: item.argument = (64'd1 << $urandom_range(0, 63))
					- 64'($urandom_range(0, 1));
			endcase
			send_item(item, "");
		end
		start <= 1'b0;

		while (chars_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[printf_number_formatter_core] OK");
		end else begin
			$display("[printf_number_formatter_core] ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/pnf_pkg.sv
src/pnf_ctrl.sv
src/pnf_datapath.sv
src/printf_number_formatter_core.sv
bench/printf_number_formatter_core_tb.sv
